FILE: src/bcpm_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Battery pack monitor package
// Widths, register indexes, health codes and fixed-point reciprocal constants.
// -----------------------------------------------------------------------------
package bcpm_pkg;

   // Number of cells in one scan (2..16).
   localparam int CELLS = 4;

   localparam int RAW_W    = 12;
   localparam int MV_W     = 13;
   localparam int IMB_W    = 11;
   localparam int IDX_W    = 4;
   localparam int VSUM_W   = 17;
   localparam int CSUM_W   = 18;
   localparam int CHARGE_W = 14;
   localparam int GRADE_W  = 7;
   localparam int CODE_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [IDX_W-1:0] CELL_LAST = IDX_W'(CELLS - 1);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELL_LOW      = 3'd0,
      CSR_CELL_HIGH     = 3'd1,
      CSR_MINOR_IMB     = 3'd2,
      CSR_CRITICAL_IMB  = 3'd3,
      CSR_SOH_STEP1     = 3'd4,
      CSR_SOH_STEP2     = 3'd5,
      CSR_SOH_STEP3     = 3'd6
   } csr_index_type;

   // Pack health codes.
   typedef enum logic [CODE_W-1:0] {
      HEALTH_OK       = 2'd0,
      HEALTH_MINOR    = 2'd1,
      HEALTH_CRITICAL = 2'd2,
      HEALTH_FAILURE  = 2'd3
   } health_code_type;

   localparam logic [GRADE_W-1:0] GRADE_A = 7'd100;
   localparam logic [GRADE_W-1:0] GRADE_B = 7'd95;
   localparam logic [GRADE_W-1:0] GRADE_C = 7'd90;
   localparam logic [GRADE_W-1:0] GRADE_D = 7'd80;

   // Register reset values.
   localparam logic [MV_W-1:0]  CELL_LOW_RST     = 13'd3000;
   localparam logic [MV_W-1:0]  CELL_HIGH_RST    = 13'd4200;
   localparam logic [IMB_W-1:0] MINOR_IMB_RST    = 11'd100;
   localparam logic [IMB_W-1:0] CRITICAL_IMB_RST = 11'd200;
   localparam logic [IMB_W-1:0] SOH_STEP1_RST    = 11'd50;
   localparam logic [IMB_W-1:0] SOH_STEP2_RST    = 11'd150;
   localparam logic [IMB_W-1:0] SOH_STEP3_RST    = 11'd300;

   // Sample to millivolts: mv = 2500 + floor((raw*3600 + 4095) / 8190).
   // The quotient is exact as floor(n * ceil(2^37/8190) / 2^37) for n < 2^24.
   localparam logic [MV_W-1:0] MV_BASE   = 13'd2500;
   localparam int              MV_FRAC   = 37;
   localparam int              MV_PROD_W = 50;
   localparam logic [63:0] MV_RECIP = ((64'd1 << MV_FRAC) + 64'd8189) / 64'd8190;
   localparam logic [63:0] MV_SCALE = 64'd3600 * MV_RECIP;
   localparam logic [63:0] MV_BIAS  = 64'd4095 * MV_RECIP;

   // Cell charge: floor(((mv-3000)*50 + 3) / 6), exact with ceil(2^19/6) for n < 2^16.
   localparam logic [MV_W-1:0]     CHG_EMPTY_MV = 13'd3000;
   localparam logic [MV_W-1:0]     CHG_FULL_MV  = 13'd4200;
   localparam logic [CHARGE_W-1:0] CHG_FULL     = 14'd10000;
   localparam int                  CHG_FRAC     = 19;
   localparam int                  CHG_PROD_W   = 34;
   localparam logic [63:0] CHG_RECIP = ((64'd1 << CHG_FRAC) + 64'd5) / 64'd6;
   localparam logic [63:0] CHG_SCALE = 64'd50 * CHG_RECIP;
   localparam logic [63:0] CHG_BIAS  = 64'd3 * CHG_RECIP;

   // Averages: sum / CELLS as a multiply by ceil(2^k / CELLS), k = sum width + 4.
   localparam int VAVG_FRAC   = VSUM_W + 4;
   localparam int VAVG_PROD_W = VSUM_W + VAVG_FRAC + 1;
   localparam logic [63:0] VAVG_RECIP =
      ((64'd1 << VAVG_FRAC) + 64'(CELLS) - 64'd1) / 64'(CELLS);
   localparam int CAVG_FRAC   = CSUM_W + 4;
   localparam int CAVG_PROD_W = CSUM_W + CAVG_FRAC + 1;
   localparam logic [63:0] CAVG_RECIP =
      ((64'd1 << CAVG_FRAC) + 64'(CELLS) - 64'd1) / 64'(CELLS);

endpackage
`default_nettype wire

FILE: src/battery_cell_pack_monitor.sv
`default_nettype none
// After the last sample of a scan is accepted, its result is registered in
// the voltage register, scan snapshot and result register, in that order.
// Throughput: one sample per cycle while req_ready is high; the ready chain
// through the four stage registers lets bubbles collapse, so samples flow on
// past a waiting result until the stages fill. Synchronous active-high reset
// clears valid flags, counter, sums and fail flag and loads threshold defaults.
// -----------------------------------------------------------------------------
// Battery cell pack monitor
// Converts per-cell ADC samples to millivolts and charge, tracks the scan
// extremes and window violations, and reports a pack summary once per scan.
// -----------------------------------------------------------------------------
module battery_cell_pack_monitor (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Sample channel.
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [bcpm_pkg::RAW_W-1:0]         req_raw_sample,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [bcpm_pkg::VSUM_W-1:0]             rsp_pack_mv,
   output logic [bcpm_pkg::MV_W-1:0]               rsp_average_mv,
   output logic [bcpm_pkg::IMB_W-1:0]              rsp_imbalance_mv,
   output logic [bcpm_pkg::IDX_W-1:0]              rsp_weakest_index,
   output logic [bcpm_pkg::IDX_W-1:0]              rsp_strongest_index,
   output logic [bcpm_pkg::CHARGE_W-1:0]           rsp_charge_level,
   output logic [bcpm_pkg::GRADE_W-1:0]            rsp_health_grade,
   output logic [bcpm_pkg::CODE_W-1:0]             rsp_health_code,
   // Configuration write channel.
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bcpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bcpm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bcpm_pkg::*;

   // ---------------------------------------------------------------------------
   // Configuration registers. Writes are always taken; an index past the last
   // register is dropped, and data is truncated to each register's width.
   // ---------------------------------------------------------------------------
   logic [MV_W-1:0]  cell_low_ff, cell_low_in;
   logic [MV_W-1:0]  cell_high_ff, cell_high_in;
   logic [IMB_W-1:0] minor_imb_ff, minor_imb_in;
   logic [IMB_W-1:0] critical_imb_ff, critical_imb_in;
   logic [IMB_W-1:0] soh_step1_ff, soh_step1_in;
   logic [IMB_W-1:0] soh_step2_ff, soh_step2_in;
   logic [IMB_W-1:0] soh_step3_ff, soh_step3_in;
   logic             csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cell_low_in     = cell_low_ff;
      cell_high_in    = cell_high_ff;
      minor_imb_in    = minor_imb_ff;
      critical_imb_in = critical_imb_ff;
      soh_step1_in    = soh_step1_ff;
      soh_step2_in    = soh_step2_ff;
      soh_step3_in    = soh_step3_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_CELL_LOW:     cell_low_in     = csr_data;
            CSR_CELL_HIGH:    cell_high_in    = csr_data;
            CSR_MINOR_IMB:    minor_imb_in    = csr_data[IMB_W-1:0];
            CSR_CRITICAL_IMB: critical_imb_in = csr_data[IMB_W-1:0];
            CSR_SOH_STEP1:    soh_step1_in    = csr_data[IMB_W-1:0];
            CSR_SOH_STEP2:    soh_step2_in    = csr_data[IMB_W-1:0];
            CSR_SOH_STEP3:    soh_step3_in    = csr_data[IMB_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_low_ff     <= CELL_LOW_RST;
         cell_high_ff    <= CELL_HIGH_RST;
         minor_imb_ff    <= MINOR_IMB_RST;
         critical_imb_ff <= CRITICAL_IMB_RST;
         soh_step1_ff    <= SOH_STEP1_RST;
         soh_step2_ff    <= SOH_STEP2_RST;
         soh_step3_ff    <= SOH_STEP3_RST;
      end else begin
         cell_low_ff     <= cell_low_in;
         cell_high_ff    <= cell_high_in;
         minor_imb_ff    <= minor_imb_in;
         critical_imb_ff <= critical_imb_in;
         soh_step1_ff    <= soh_step1_in;
         soh_step2_ff    <= soh_step2_in;
         soh_step3_ff    <= soh_step3_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Flow control. Each stage can load when it is empty or when its contents
   // move on in the same cycle. Only the last cell of a scan fills the
   // snapshot stage, so a waiting result blocks samples only once the
   // snapshot, voltage and sample stages behind it are occupied as well.
   // ---------------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free, s3_ready, s2_ready, s1_ready;
   logic acc_take, scan_last, rsp_load;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || rsp_free;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign acc_take = s2_valid_ff && s3_ready;
   assign rsp_load = s3_valid_ff && rsp_free;

   assign s1_valid_in  = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_ready ? (acc_take && scan_last) : s3_valid_ff;
   assign rsp_valid_in = rsp_free ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: sample register.
   // Stage 2: voltage register. The conversion is one constant multiply whose
   // upper bits are the rounded quotient by 8190.
   // ---------------------------------------------------------------------------
   logic [RAW_W-1:0]     s1_raw_ff;
   logic [MV_W-1:0]      s2_mv_ff, s2_mv_in;
   logic [MV_PROD_W-1:0] mv_prod;

   assign mv_prod  = MV_PROD_W'(s1_raw_ff) * MV_PROD_W'(MV_SCALE) + MV_PROD_W'(MV_BIAS);
   assign s2_mv_in = MV_BASE + MV_W'(mv_prod[MV_FRAC +: IMB_W]);

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_raw_ff <= req_raw_sample;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_mv_ff <= s2_mv_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Scan accumulators. The cell charge is clamped to empty below the lower
   // knee and to full above the upper knee; between the two it is a constant
   // multiply standing in for the rounded division by 6.
   // ---------------------------------------------------------------------------
   logic [MV_W-1:0]       chg_delta;
   logic [CHG_PROD_W-1:0] chg_prod;
   logic [CHARGE_W-1:0]   cell_charge;

   assign chg_delta = s2_mv_ff - CHG_EMPTY_MV;
   assign chg_prod  = CHG_PROD_W'(chg_delta[IMB_W-1:0]) * CHG_PROD_W'(CHG_SCALE)
                    + CHG_PROD_W'(CHG_BIAS);

   always_comb begin
      priority if (s2_mv_ff <= CHG_EMPTY_MV) begin
         cell_charge = '0;
      end else if (s2_mv_ff >= CHG_FULL_MV) begin
         cell_charge = CHG_FULL;
      end else begin
         cell_charge = chg_prod[CHG_FRAC +: CHARGE_W];
      end
   end

   logic [IDX_W-1:0]  cell_counter_ff, cell_counter_in;
   logic [VSUM_W-1:0] voltage_sum_ff, voltage_sum_in, voltage_sum_next;
   logic [CSUM_W-1:0] charge_sum_ff, charge_sum_in, charge_sum_next;
   logic [MV_W-1:0]   lowest_mv_ff, lowest_mv_in, lowest_mv_next;
   logic [MV_W-1:0]   highest_mv_ff, highest_mv_in, highest_mv_next;
   logic [IDX_W-1:0]  lowest_idx_ff, lowest_idx_in, lowest_idx_next;
   logic [IDX_W-1:0]  highest_idx_ff, highest_idx_in, highest_idx_next;
   logic              window_fail_ff, window_fail_in, window_fail_next;
   logic              scan_first;

   assign scan_first = (cell_counter_ff == '0);
   assign scan_last  = (cell_counter_ff == CELL_LAST);

   // Values after folding in the cell at the head of stage 2.
   always_comb begin
      voltage_sum_next = voltage_sum_ff + VSUM_W'(s2_mv_ff);
      charge_sum_next  = charge_sum_ff + CSUM_W'(cell_charge);
      lowest_mv_next   = lowest_mv_ff;
      lowest_idx_next  = lowest_idx_ff;
      highest_mv_next  = highest_mv_ff;
      highest_idx_next = highest_idx_ff;
      // The first cell seeds both extremes; later ones replace them only
      // when strictly beyond, so the earliest cell keeps a tie.
      if (scan_first || s2_mv_ff < lowest_mv_ff) begin
         lowest_mv_next  = s2_mv_ff;
         lowest_idx_next = cell_counter_ff;
      end
      if (scan_first || s2_mv_ff > highest_mv_ff) begin
         highest_mv_next  = s2_mv_ff;
         highest_idx_next = cell_counter_ff;
      end
      window_fail_next = window_fail_ff
                       || (s2_mv_ff < cell_low_ff) || (s2_mv_ff > cell_high_ff);
   end

   // At the end of a scan the sums restart from zero; the folded values go
   // to the snapshot stage instead.
   always_comb begin
      cell_counter_in = cell_counter_ff;
      voltage_sum_in  = voltage_sum_ff;
      charge_sum_in   = charge_sum_ff;
      lowest_mv_in    = lowest_mv_ff;
      highest_mv_in   = highest_mv_ff;
      lowest_idx_in   = lowest_idx_ff;
      highest_idx_in  = highest_idx_ff;
      window_fail_in  = window_fail_ff;
      if (acc_take) begin
         if (scan_last) begin
            cell_counter_in = '0;
            voltage_sum_in  = '0;
            charge_sum_in   = '0;
            window_fail_in  = 1'b0;
         end else begin
            cell_counter_in = cell_counter_ff + 1'b1;
            voltage_sum_in  = voltage_sum_next;
            charge_sum_in   = charge_sum_next;
            lowest_mv_in    = lowest_mv_next;
            highest_mv_in   = highest_mv_next;
            lowest_idx_in   = lowest_idx_next;
            highest_idx_in  = highest_idx_next;
            window_fail_in  = window_fail_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_counter_ff <= '0;
         voltage_sum_ff  <= '0;
         charge_sum_ff   <= '0;
         window_fail_ff  <= 1'b0;
      end else begin
         cell_counter_ff <= cell_counter_in;
         voltage_sum_ff  <= voltage_sum_in;
         charge_sum_ff   <= charge_sum_in;
         window_fail_ff  <= window_fail_in;
      end
   end

   // Extremes are seeded by the first cell of every scan.
   always_ff @(posedge clock) begin
      lowest_mv_ff   <= lowest_mv_in;
      highest_mv_ff  <= highest_mv_in;
      lowest_idx_ff  <= lowest_idx_in;
      highest_idx_ff <= highest_idx_in;
   end

   // ---------------------------------------------------------------------------
   // Stage 3: scan snapshot, loaded with the last cell of each scan.
   // ---------------------------------------------------------------------------
   logic [VSUM_W-1:0] s3_vsum_ff;
   logic [CSUM_W-1:0] s3_csum_ff;
   logic [MV_W-1:0]   s3_low_ff, s3_high_ff;
   logic [IDX_W-1:0]  s3_low_idx_ff, s3_high_idx_ff;
   logic              s3_fail_ff;

   always_ff @(posedge clock) begin
      if (acc_take && scan_last) begin
         s3_vsum_ff     <= voltage_sum_next;
         s3_csum_ff     <= charge_sum_next;
         s3_low_ff      <= lowest_mv_next;
         s3_high_ff     <= highest_mv_next;
         s3_low_idx_ff  <= lowest_idx_next;
         s3_high_idx_ff <= highest_idx_next;
         s3_fail_ff     <= window_fail_next;
      end
   end

   // ---------------------------------------------------------------------------
   // Summary: averages by reciprocal multiply, imbalance and its two
   // classification chains. The chains follow the register values as
   // written, even when the thresholds are out of order.
   // ---------------------------------------------------------------------------
   logic [VAVG_PROD_W-1:0] vavg_prod;
   logic [CAVG_PROD_W-1:0] cavg_prod;
   logic [MV_W-1:0]        imb_wide;
   logic [IMB_W-1:0]       imbalance;
   logic [GRADE_W-1:0]     grade;
   health_code_type        code;

   assign vavg_prod = VAVG_PROD_W'(s3_vsum_ff) * VAVG_PROD_W'(VAVG_RECIP);
   assign cavg_prod = CAVG_PROD_W'(s3_csum_ff) * CAVG_PROD_W'(CAVG_RECIP);
   assign imb_wide  = s3_high_ff - s3_low_ff;
   assign imbalance = imb_wide[IMB_W-1:0];

   always_comb begin
      priority if (imbalance < soh_step1_ff) begin
         grade = GRADE_A;
      end else if (imbalance < soh_step2_ff) begin
         grade = GRADE_B;
      end else if (imbalance < soh_step3_ff) begin
         grade = GRADE_C;
      end else begin
         grade = GRADE_D;
      end
   end

   always_comb begin
      priority if (s3_fail_ff) begin
         code = HEALTH_FAILURE;
      end else if (imbalance < minor_imb_ff) begin
         code = HEALTH_OK;
      end else if (imbalance < critical_imb_ff) begin
         code = HEALTH_MINOR;
      end else begin
         code = HEALTH_CRITICAL;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: result register, held until the result beat is taken.
   // ---------------------------------------------------------------------------
   logic [VSUM_W-1:0]   rsp_pack_ff;
   logic [MV_W-1:0]     rsp_avg_ff;
   logic [IMB_W-1:0]    rsp_imb_ff;
   logic [IDX_W-1:0]    rsp_weak_ff, rsp_strong_ff;
   logic [CHARGE_W-1:0] rsp_charge_ff;
   logic [GRADE_W-1:0]  rsp_grade_ff;
   health_code_type     rsp_code_ff;

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pack_ff   <= s3_vsum_ff;
         rsp_avg_ff    <= vavg_prod[VAVG_FRAC +: MV_W];
         rsp_imb_ff    <= imbalance;
         rsp_weak_ff   <= s3_low_idx_ff;
         rsp_strong_ff <= s3_high_idx_ff;
         rsp_charge_ff <= cavg_prod[CAVG_FRAC +: CHARGE_W];
         rsp_grade_ff  <= grade;
         rsp_code_ff   <= code;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pack_mv         = rsp_pack_ff;
   assign rsp_average_mv      = rsp_avg_ff;
   assign rsp_imbalance_mv    = rsp_imb_ff;
   assign rsp_weakest_index   = rsp_weak_ff;
   assign rsp_strongest_index = rsp_strong_ff;
   assign rsp_charge_level    = rsp_charge_ff;
   assign rsp_health_grade    = rsp_grade_ff;
   assign rsp_health_code     = rsp_code_ff;

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      cell_counter_ff <= CELL_LAST)
      else $error("cell counter ran past the last cell");

   a_scan_restart: assert property (@(posedge clock) disable iff (reset)
      acc_take && scan_last |=> cell_counter_ff == '0 && s3_valid_ff)
      else $error("end of scan did not restart the counter and fill the snapshot");

   a_average_exact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (20'(rsp_avg_ff) * 20'(CELLS) <= 20'(rsp_pack_ff))
                    && (20'(rsp_pack_ff) - 20'(rsp_avg_ff) * 20'(CELLS) < 20'(CELLS)))
      else $error("average voltage is not the floored quotient of the pack voltage");

   a_charge_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_charge_ff <= CHG_FULL)
      else $error("charge level above full");

   a_grade_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_grade_ff == GRADE_A || rsp_grade_ff == GRADE_B
                    || rsp_grade_ff == GRADE_C || rsp_grade_ff == GRADE_D)
      else $error("health grade is not one of the four grades");

endmodule
`default_nettype wire
